// File: hdl/tcpg_pkg.sv
// Shared types and constants of the text cell pixel generator.
`default_nettype none
package tcpg_pkg;

  // Item kinds carried in the mode field; the fourth code is unused.
  typedef enum logic [1:0] {
    MODE_VIDEO_WR = 2'd0,
    MODE_GLYPH_WR = 2'd1,
    MODE_RENDER   = 2'd2
  } mode_t;

  // Input word.
  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] address;
    logic [7:0]  data;
    logic [7:0]  line;
    logic [5:0]  column;
  } in_word_t;

  // Result word, one per pixel.
  typedef struct packed {
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_word_t;

  // A looked-up cell waiting to be drawn.
  typedef struct packed {
    logic [7:0] glyph;
    logic [2:0] fg;
    logic [2:0] bg;
    logic [5:0] column;
    logic [7:0] line;
  } cell_t;

  localparam logic [7:0] LEVEL_ON  = 8'hff;
  localparam logic [7:0] LEVEL_OFF = 8'h00;

endpackage
`default_nettype wire

// File: hdl/tcpg_ram.sv
// Generic simple dual-port RAM with registered, enabled read.
`default_nettype none
module tcpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/tcpg_front.sv
// Front end: accepts words, performs store writes and looks up each rendered cell.
`default_nettype none
module tcpg_front #(
  parameter int VIDEO_BYTES = 4096,
  parameter int GLYPH_BYTES = 2048,
  parameter int COLUMNS     = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tcpg_pkg::in_word_t in_word,
  output logic                   cell_valid,
  input  wire logic              cell_full,
  output tcpg_pkg::cell_t        cell_data
);

  // The video store is split into an even bank (codes) and an odd bank
  // (attributes), so one cell reads both bytes in the same cycle.
  localparam int BANK_DEPTH = VIDEO_BYTES / 2;
  localparam int BA_W       = $clog2(BANK_DEPTH);
  localparam int GA_W       = $clog2(GLYPH_BYTES);

  logic       advance;
  logic       accept;
  logic       even_we;
  logic       odd_we;
  logic       glyph_we;
  logic       render_ok;
  logic [31:0] wr_word_addr;
  logic [31:0] rd_word_addr;
  logic [31:0] glyph_wr_addr;
  logic [31:0] glyph_rd_addr;
  logic [7:0] code;
  logic [7:0] attr;
  logic [7:0] glyph;
  logic       flag_eff;
  logic [2:0] row;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_line_r;
  logic [5:0] s1_column_r;
  logic       s2_valid_r, s2_valid_nxt;
  logic [7:0] s2_line_r;
  logic [5:0] s2_column_r;
  logic [2:0] s2_fg_r;
  logic [2:0] s2_bg_r;
  logic       flag_r, flag_nxt;

  // The whole front moves together; it holds while a finished cell cannot enter the queue.
  assign advance  = !s2_valid_r || !cell_full;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  assign even_we  = accept && (in_word.mode == tcpg_pkg::MODE_VIDEO_WR) && !in_word.address[0];
  assign odd_we   = accept && (in_word.mode == tcpg_pkg::MODE_VIDEO_WR) && in_word.address[0];
  assign glyph_we = accept && (in_word.mode == tcpg_pkg::MODE_GLYPH_WR);

  assign render_ok = (in_word.mode == tcpg_pkg::MODE_RENDER) &&
                     (32'(in_word.column) < COLUMNS);

  assign wr_word_addr  = 32'(in_word.address[11:1]);
  assign rd_word_addr  = 32'({in_word.line[7:3], in_word.column});
  assign glyph_wr_addr = 32'(in_word.address);

  tcpg_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (wr_word_addr[BA_W-1:0]),
    .wdata (in_word.data),
    .re    (advance),
    .raddr (rd_word_addr[BA_W-1:0]),
    .rdata (code)
  );

  tcpg_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (wr_word_addr[BA_W-1:0]),
    .wdata (in_word.data),
    .re    (advance),
    .raddr (rd_word_addr[BA_W-1:0]),
    .rdata (attr)
  );

  // Column 0 reloads the double-height flag and uses the new value itself.
  assign flag_eff      = (s1_column_r == 6'd0) ? code[7] : flag_r;
  assign row           = flag_eff ? s1_line_r[3:1] : s1_line_r[2:0];
  assign glyph_rd_addr = 32'({code, row});

  tcpg_ram #(.WIDTH(8), .DEPTH(GLYPH_BYTES)) u_glyph_ram (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (glyph_wr_addr[GA_W-1:0]),
    .wdata (in_word.data),
    .re    (advance),
    .raddr (glyph_rd_addr[GA_W-1:0]),
    .rdata (glyph)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    flag_nxt     = flag_r;
    if (advance) begin
      s1_valid_nxt = accept && render_ok;
      s2_valid_nxt = s1_valid_r;
      if (s1_valid_r && (s1_column_r == 6'd0)) begin
        flag_nxt = code[7];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      flag_r     <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      flag_r     <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_line_r   <= in_word.line;
      s1_column_r <= in_word.column;
      s2_line_r   <= s1_line_r;
      s2_column_r <= s1_column_r;
      s2_fg_r     <= attr[2:0];
      s2_bg_r     <= attr[5:3];
    end
  end

  assign cell_valid       = s2_valid_r;
  assign cell_data.glyph  = glyph;
  assign cell_data.fg     = s2_fg_r;
  assign cell_data.bg     = s2_bg_r;
  assign cell_data.column = s2_column_r;
  assign cell_data.line   = s2_line_r;

endmodule
`default_nettype wire

// File: hdl/tcpg_queue.sv
// Small first-in first-out queue of looked-up cells.
`default_nettype none
module tcpg_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tcpg_pkg::cell_t push_cell,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output tcpg_pkg::cell_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcpg_pkg::cell_t   slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (32'(count_r) == DEPTH);
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointers wrap at the last slot, so any depth works.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cell;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tcpg_back.sv
// Back end: expands each queued cell into pixels, one per cycle while out_ready lets them go, into the output register.
`default_nettype none
module tcpg_back #(
  parameter int PIXELS_PER_CELL = 6
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            empty,
  input  wire tcpg_pkg::cell_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tcpg_pkg::out_word_t  out_word
);

  localparam int PIX_W = (PIXELS_PER_CELL > 1) ? $clog2(PIXELS_PER_CELL) : 1;
  localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(PIXELS_PER_CELL - 1);

  logic               load;
  logic               emit;
  logic               last;
  logic [2:0]         bit_sel;
  logic [2:0]         colour;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic               out_valid_r, out_valid_nxt;
  tcpg_pkg::out_word_t out_word_r, out_word_nxt;

  assign load    = !out_valid_r || out_ready;
  assign emit    = load && !empty;
  assign last    = (pix_r == LAST_PIX);
  assign pop     = emit && last;
  assign bit_sel = 3'd7 - 3'(pix_r);
  assign colour  = head.glyph[bit_sel] ? head.fg : head.bg;

  always_comb begin
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      pix_nxt       = last ? '0 : pix_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_word_nxt.pixel_x    = {head.column, 3'b000} + 9'(pix_r);
    out_word_nxt.pixel_y    = head.line;
    out_word_nxt.red        = colour[0] ? tcpg_pkg::LEVEL_ON : tcpg_pkg::LEVEL_OFF;
    out_word_nxt.green      = colour[1] ? tcpg_pkg::LEVEL_ON : tcpg_pkg::LEVEL_OFF;
    out_word_nxt.blue       = colour[2] ? tcpg_pkg::LEVEL_ON : tcpg_pkg::LEVEL_OFF;
    out_word_nxt.last_pixel = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pix_r       <= pix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// File: hdl/text_cell_pixel_generator_core.sv
// Top level of the text cell pixel generator: front end, cell queue and pixel back end.
//
// Usage: every input word is a store write or a cell render, chosen by its mode field.
// Video writes fill a byte of the video store (codes at even, attributes at odd
// addresses); glyph writes fill a byte of the glyph store. Neither gives a result.
// A render word names a scan line and a column and yields PIXELS_PER_CELL pixel
// words, leftmost first, the last one flagged by last_pixel. Renders of columns
// at or beyond COLUMNS and words of the unused mode are dropped.
// Both channels use valid/ready; a word moves when both are high.
// Path: a render word passes the video read, the glyph read, the queue and the
// output register before the first pixel of its cell is valid.
// Throughput: the input takes one word per cycle while in_ready is high. The back end
// sends one pixel per cycle unless out_ready holds it, PIXELS_PER_CELL per cell; this
// pixel loop sets the sustained rate, and writes slot in for free.
// Stalls: when the receiver holds out_ready low, the output register holds its
// pixel, cells collect in the QUEUE_DEPTH-entry queue, and once it is full the
// front end freezes and drops in_ready. Reset clears the pipeline, the queue and
// the double-height flag; store contents are undefined until written.
// Store sizes are expected to be powers of two.
`default_nettype none
module text_cell_pixel_generator_core #(
  parameter int VIDEO_BYTES     = 4096,
  parameter int GLYPH_BYTES     = 2048,
  parameter int COLUMNS         = 64,
  parameter int PIXELS_PER_CELL = 6,
  parameter int QUEUE_DEPTH     = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tcpg_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tcpg_pkg::out_word_t      out_word
);

  // Cells leave the front end from its second stage straight into the queue.
  logic            cell_valid;
  logic            cell_full;
  tcpg_pkg::cell_t cell_data;
  logic            q_pop;
  logic            q_empty;
  tcpg_pkg::cell_t q_head;

  tcpg_front #(
    .VIDEO_BYTES (VIDEO_BYTES),
    .GLYPH_BYTES (GLYPH_BYTES),
    .COLUMNS     (COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .cell_valid (cell_valid),
    .cell_full  (cell_full),
    .cell_data  (cell_data)
  );

  // A finished cell waits in the front end's second stage until the queue
  // has room, and is pushed at the first edge where it does.
  tcpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cell_valid && !cell_full),
    .push_cell (cell_data),
    .full      (cell_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tcpg_back #(
    .PIXELS_PER_CELL (PIXELS_PER_CELL)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// File: tb/text_cell_pixel_generator_core_test.sv
// Self-checking testbench of the text cell pixel generator core: directed and random words.
module text_cell_pixel_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes of the block as instantiated below (the core's defaults).
  localparam int VIDEO_BYTES     = 4096;
  localparam int GLYPH_BYTES     = 2048;
  localparam int COLUMNS         = 64;
  localparam int PIXELS_PER_CELL = 6;

  // The fourth mode code has no name in the package; the core must drop it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Wait after the last expected pixel, so that any cell still in flight
  // can come out before we move on.
  localparam int DRAIN_CYCLES = 8;
  // Cycles in a row with no word moving on either channel before we give up.
  localparam int STALL_LIMIT  = 1000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  tcpg_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tcpg_pkg::out_word_t out_word;

  text_cell_pixel_generator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // Mirror of the block's state. The known bits record which store bytes have
  // been written, so that no render ever reads a byte the core never received.
  logic [7:0] video_mirror [VIDEO_BYTES];
  logic [7:0] glyph_mirror [GLYPH_BYTES];
  bit         video_known  [VIDEO_BYTES];
  bit         glyph_known  [GLYPH_BYTES];
  bit         tall_rows = 1'b0;

  tcpg_pkg::out_word_t pending_pixels [$];
  tcpg_pkg::out_word_t want;
  int         error_count  = 0;
  int         words_sent   = 0;
  int         quiet_cycles = 0;
  bit         idle_on      = 1'b1;

  initial begin
    forever #4 clk = ~clk;
  end

  // Updates the mirror with an accepted word and queues the pixels it must give.
  task automatic track_word(tcpg_pkg::in_word_t w);
    int         base;
    logic [7:0] code;
    logic [7:0] attr;
    logic [7:0] glyph;
    logic [2:0] row;
    logic [2:0] fg;
    logic [2:0] bg;
    logic [2:0] color;
    tcpg_pkg::out_word_t px;
    unique case (w.mode)
      tcpg_pkg::MODE_VIDEO_WR: begin
        video_mirror[w.address % VIDEO_BYTES] = w.data;
        video_known[w.address % VIDEO_BYTES]  = 1'b1;
      end
      tcpg_pkg::MODE_GLYPH_WR: begin
        glyph_mirror[w.address % GLYPH_BYTES] = w.data;
        glyph_known[w.address % GLYPH_BYTES]  = 1'b1;
      end
      tcpg_pkg::MODE_RENDER: begin
        if (w.column < COLUMNS) begin
          // Code byte at the even address, attribute right after it.
          base = ((w.line / 8) * 128 + 2 * w.column) % VIDEO_BYTES;
          code = video_mirror[base];
          attr = video_mirror[(base + 1) % VIDEO_BYTES];
          // Only a column-0 cell reloads the double-height flag, and it takes
          // effect on that very cell; other columns use whatever is held.
          if (w.column == 0) begin
            tall_rows = code[7];
          end
          row   = tall_rows ? w.line[3:1] : w.line[2:0];
          glyph = glyph_mirror[(code * 8 + row) % GLYPH_BYTES];
          fg    = attr[2:0];
          bg    = attr[5:3];
          // Leftmost pixel comes from the glyph's top bit; the two low glyph
          // bits are never shown.
          for (int i = 0; i < PIXELS_PER_CELL; i++) begin
            color         = glyph[7 - i] ? fg : bg;
            px.pixel_x    = 9'(w.column * 8 + i);
            px.pixel_y    = w.line;
            px.red        = color[0] ? tcpg_pkg::LEVEL_ON : tcpg_pkg::LEVEL_OFF;
            px.green      = color[1] ? tcpg_pkg::LEVEL_ON : tcpg_pkg::LEVEL_OFF;
            px.blue       = color[2] ? tcpg_pkg::LEVEL_ON : tcpg_pkg::LEVEL_OFF;
            px.last_pixel = (i == PIXELS_PER_CELL - 1);
            pending_pixels.push_back(px);
          end
        end
      end
      default: begin
        // The unused mode changes nothing.
      end
    endcase
  endtask

  // Offers one word and returns at the edge where it is accepted. Valid stays
  // high afterwards; the next call or the drain decides when it drops, so it
  // never gets two assignments in one time step.
  task automatic send_word(tcpg_pkg::in_word_t w);
    while (idle_on && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    track_word(w);
    if (w.mode != MODE_UNUSED) begin
      words_sent++;
    end
  endtask

  // Store write; the render-only fields carry random junk.
  task automatic send_write(logic [1:0] mode, logic [11:0] address, logic [7:0] data);
    tcpg_pkg::in_word_t w;
    w.mode    = mode;
    w.address = address;
    w.data    = data;
    w.line    = 8'($urandom);
    w.column  = 6'($urandom);
    send_word(w);
  endtask

  // Word of the unused mode with every field random.
  task automatic send_noise();
    tcpg_pkg::in_word_t w;
    w         = tcpg_pkg::in_word_t'($urandom);
    w.mode    = MODE_UNUSED;
    w.address = 12'($urandom);
    send_word(w);
  endtask

  // Renders one cell, first writing with random content any code, attribute or
  // glyph byte that the cell will read and that has never been written.
  task automatic render_cell(logic [7:0] line, logic [5:0] column);
    int         base;
    int         gidx;
    logic [7:0] code;
    logic [2:0] row;
    logic       tall;
    tcpg_pkg::in_word_t w;
    base = ((line / 8) * 128 + 2 * column) % VIDEO_BYTES;
    if (!video_known[base]) begin
      send_write(tcpg_pkg::MODE_VIDEO_WR, 12'(base), 8'($urandom));
    end
    if (!video_known[(base + 1) % VIDEO_BYTES]) begin
      send_write(tcpg_pkg::MODE_VIDEO_WR, 12'((base + 1) % VIDEO_BYTES), 8'($urandom));
    end
    code = video_mirror[base];
    tall = (column == 0) ? code[7] : tall_rows;
    row  = tall ? line[3:1] : line[2:0];
    gidx = (code * 8 + row) % GLYPH_BYTES;
    if (!glyph_known[gidx]) begin
      // Half the time the glyph address has its top bit set, so it must wrap.
      send_write(tcpg_pkg::MODE_GLYPH_WR, 12'(gidx + GLYPH_BYTES * $urandom_range(0, 1)),
                 8'($urandom));
    end
    w.mode    = tcpg_pkg::MODE_RENDER;
    w.address = 12'($urandom);
    w.data    = 8'($urandom);
    w.line    = line;
    w.column  = column;
    send_word(w);
  endtask

  // The sender holds off until every queued pixel has arrived, then waits a
  // little longer so that nothing is still in flight inside the core.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Field extremes: first and last line and column, top and bottom store
  // addresses, all-zero and all-one bytes, and a glyph write that wraps.
  task automatic test_extremes();
    // Last cell of the screen, rendered before any column-0 cell, so the flag
    // is still the one from reset.
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'hffe, 8'h7f);
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'hfff, 8'hf8);
    send_write(tcpg_pkg::MODE_GLYPH_WR, 12'hbff, 8'h81);
    render_cell(8'd255, 6'd63);
    // First cell of the screen: white on black, solid glyph row.
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'h000, 8'h00);
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'h001, 8'h07);
    send_write(tcpg_pkg::MODE_GLYPH_WR, 12'h000, 8'hff);
    render_cell(8'd0, 6'd0);
    // Highest code on the bottom glyph row, empty glyph byte.
    send_write(tcpg_pkg::MODE_GLYPH_WR, 12'hfff, 8'h00);
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'h002, 8'hff);
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'h003, 8'h1c);
    render_cell(8'd7, 6'd1);
  endtask

  // Double height set by a column-0 code with its top bit, held across other
  // columns and lines, then cleared by a column-0 code without it.
  task automatic test_double_height();
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'd256, 8'hc3);
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'd257, 8'h2a);
    render_cell(8'd21, 6'd0);
    render_cell(8'd21, 6'd9);
    render_cell(8'd200, 6'd40);
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'd256, 8'h43);
    render_cell(8'd17, 6'd0);
    render_cell(8'd17, 6'd9);
  endtask

  // Words of the unused mode must leave the stores and the flag alone. The
  // column field is only six bits wide, so a column past the end cannot occur.
  task automatic test_ignored_words();
    tcpg_pkg::in_word_t w;
    send_write(tcpg_pkg::MODE_VIDEO_WR, 12'd256, 8'h80);
    render_cell(8'd16, 6'd0);
    w = '1;
    send_word(w);
    w         = '0;
    w.mode    = MODE_UNUSED;
    w.data    = 8'h80;
    w.address = 12'd256;
    send_word(w);
    send_noise();
    render_cell(8'd19, 6'd12);
  endtask

  // Mostly complete cells (their missing bytes written first, then the
  // render), with stray writes and unused-mode words mixed in.
  task automatic test_random(int quota, bit idling);
    int first;
    int pick;
    idle_on = idling;
    first   = words_sent;
    while (words_sent - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        render_cell(8'($urandom), ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom));
      end else if (pick < 78) begin
        send_write(tcpg_pkg::MODE_VIDEO_WR, 12'($urandom), 8'($urandom));
      end else if (pick < 91) begin
        send_write(tcpg_pkg::MODE_GLYPH_WR, 12'($urandom), 8'($urandom));
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    wait_drain();
    test_double_height();
    wait_drain();
    test_ignored_words();
    wait_drain();
    test_random(25, 1'b0);
    wait_drain();
    test_random(40, 1'b1);
    wait_drain();
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("** text_cell_pixel_generator_core: PASSED **");
    end else begin
      $display("** text_cell_pixel_generator_core: FAILED **");
    end
    $finish;
  end

  // While idling is on, the receiver drops out_ready with a chance of nine percent.
  always @(posedge clk) begin
    out_ready <= !(idle_on && $urandom_range(0, 99) < 9);
  end

  task automatic check_field(string name, int unsigned expected, int unsigned actual);
    if (expected != actual) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, expected, actual);
      error_count++;
    end
  endtask

  // Every pixel word that moves is matched against the oldest one queued.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel word with none expected, actual %h", $time, out_word);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.pixel_x, out_word.pixel_x);
        check_field("pixel_y", want.pixel_y, out_word.pixel_y);
        check_field("red", want.red, out_word.red);
        check_field("green", want.green, out_word.green);
        check_field("blue", want.blue, out_word.blue);
        check_field("last_pixel", want.last_pixel, out_word.last_pixel);
      end
    end
  end

  // A hung handshake ends the run instead of letting it spin forever.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("** text_cell_pixel_generator_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
